[rtl/core/lom_pkg.sv]
// Package for the LIFO order matcher: stack depth, order entry, result and
// control types, and the function and side codes. No dependencies.
package lom_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   localparam logic FUNC_ADD = 1'b0;
   localparam logic FUNC_MATCH = 1'b1;
   localparam logic BUY = 1'b0;

   typedef logic [CNT_W-1:0] lom_count_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] price;
      logic [30:0] amount;
   } lom_entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic load;
   } lom_cell_ctl_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic upd;
   } lom_stack_ctl_type;

   typedef struct packed {
      logic        trade_valid;
      logic [31:0] buyer_id;
      logic [31:0] seller_id;
      logic [30:0] traded_units;
      logic [31:0] trade_price_ticks;
      logic        overflow;
      logic        last;
   } lom_result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIRST,
      ST_NEXT
   } lom_state_type;

endpackage

[rtl/core/lom_cell.sv]
// One stack cell holding a single resting order.
// Depends on lom_pkg; takes its entry from either neighbor on push or pop.
module lom_cell (
   input  logic                     clock,
   input  lom_pkg::lom_cell_ctl_type ctl,
   input  lom_pkg::lom_entry_type   from_up,
   input  lom_pkg::lom_entry_type   from_dn,
   input  logic [30:0]              load_amount,
   output lom_pkg::lom_entry_type   q
);
   import lom_pkg::*;

   lom_entry_type entry_ff;
   lom_entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctl.push) begin
         entry_in = from_up;
      end else if (ctl.pop) begin
         entry_in = from_dn;
      end else if (ctl.load) begin
         entry_in.amount = load_amount;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

[rtl/core/lom_stack.sv]
// One side's order stack: a row of cells with the top in cell zero, and a
// fill count. Depends on lom_pkg and lom_cell.
module lom_stack (
   input  logic                      clock,
   input  logic                      reset,
   input  lom_pkg::lom_stack_ctl_type ctl,
   input  lom_pkg::lom_entry_type    push_entry,
   input  logic [30:0]               upd_amount,
   output lom_pkg::lom_entry_type    top,
   output lom_pkg::lom_count_type    count,
   output logic                      full,
   output logic                      empty
);
   import lom_pkg::*;

   lom_entry_type    cell_q [STACK_DEPTH];
   lom_cell_ctl_type cell_ctl [STACK_DEPTH];
   lom_count_type    count_ff;
   lom_count_type    count_in;

   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         cell_ctl[i].push = ctl.push;
         cell_ctl[i].pop  = ctl.pop;
         cell_ctl[i].load = (i == 0) ? ctl.upd : 1'b0;
      end
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      lom_entry_type up_entry;
      lom_entry_type dn_entry;
      if (i == 0) begin : g_first
         assign up_entry = push_entry;
      end else begin : g_rest
         assign up_entry = cell_q[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_end
         assign dn_entry = cell_q[i];
      end else begin : g_mid
         assign dn_entry = cell_q[i+1];
      end
      lom_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[i]),
         .from_up     (up_entry),
         .from_dn     (dn_entry),
         .load_amount (upd_amount),
         .q           (cell_q[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      priority if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign top   = cell_q[0];
   assign count = count_ff;
   assign full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign empty = (count_ff == '0);

endmodule

[rtl/core/lifo_order_matcher_top.sv]
// Top level of the LIFO order matcher: bid and ask stacks, the match
// sequencer and the result register. Depends on lom_pkg and lom_stack.
// An add item is taken when the result register is free; its result is valid in the next cycle.
// A match item stalls the input while the sequencer is in ST_FIRST and ST_NEXT, with the
// trade step (price compare, minimum, subtract at the two stack tops) as the loop.
// The next item is taken once the last result of a match is registered.
// Synchronous reset empties both stacks, idles the sequencer and drops any result.
module lifo_order_matcher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic        req_side,
   input  logic [31:0] req_order_id,
   input  logic [31:0] req_price_ticks,
   input  logic [30:0] req_amount,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_trade_valid,
   output logic [31:0] rsp_buyer_id,
   output logic [31:0] rsp_seller_id,
   output logic [30:0] rsp_traded_units,
   output logic [31:0] rsp_trade_price_ticks,
   output logic        rsp_overflow,
   output logic        rsp_last
);
   import lom_pkg::*;

   lom_state_type     state_ff;
   lom_state_type     state_in;
   lom_stack_ctl_type bid_ctl;
   lom_stack_ctl_type ask_ctl;
   lom_entry_type     new_entry;
   lom_entry_type     bid_top;
   lom_entry_type     ask_top;
   lom_count_type     bid_count;
   lom_count_type     ask_count;
   logic              bid_full;
   logic              ask_full;
   logic              bid_empty;
   logic              ask_empty;
   logic              can_trade;
   logic [30:0]       trade_qty;
   logic [30:0]       bid_rem;
   logic [30:0]       ask_rem;
   logic              out_free;
   logic              out_load;
   logic              step_go;
   logic              accept;
   lom_result_type    out_res;
   lom_result_type    trade_res;
   lom_result_type    rsp_ff;
   lom_result_type    pend_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;

   assign new_entry.id     = req_order_id;
   assign new_entry.price  = req_price_ticks;
   assign new_entry.amount = req_amount;

   lom_stack u_bid (
      .clock      (clock),
      .reset      (reset),
      .ctl        (bid_ctl),
      .push_entry (new_entry),
      .upd_amount (bid_rem),
      .top        (bid_top),
      .count      (bid_count),
      .full       (bid_full),
      .empty      (bid_empty)
   );

   lom_stack u_ask (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ask_ctl),
      .push_entry (new_entry),
      .upd_amount (ask_rem),
      .top        (ask_top),
      .count      (ask_count),
      .full       (ask_full),
      .empty      (ask_empty)
   );

   assign can_trade = !bid_empty && !ask_empty && (bid_top.price >= ask_top.price);
   assign trade_qty = (bid_top.amount < ask_top.amount) ? bid_top.amount : ask_top.amount;
   assign bid_rem   = bid_top.amount - trade_qty;
   assign ask_rem   = ask_top.amount - trade_qty;

   always_comb begin
      trade_res                   = '0;
      trade_res.trade_valid       = 1'b1;
      trade_res.buyer_id          = bid_top.id;
      trade_res.seller_id         = ask_top.id;
      trade_res.traded_units      = trade_qty;
      trade_res.trade_price_ticks = ask_top.price;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   // Outputs of the sequencer.
   always_comb begin
      req_stall = 1'b1;
      out_load  = 1'b0;
      out_res   = '0;
      step_go   = 1'b0;
      bid_ctl   = '0;
      ask_ctl   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free && req_func == FUNC_ADD) begin
               out_load         = 1'b1;
               out_res.overflow = (req_side == BUY) ? bid_full : ask_full;
               out_res.last     = 1'b1;
               bid_ctl.push     = (req_side == BUY) && !bid_full;
               ask_ctl.push     = (req_side != BUY) && !ask_full;
            end
         end
         ST_FIRST: begin
            if (can_trade) begin
               step_go = 1'b1;
            end else if (out_free) begin
               out_load     = 1'b1;
               out_res.last = 1'b1;
            end
         end
         ST_NEXT: begin
            if (out_free) begin
               out_load     = 1'b1;
               out_res      = pend_ff;
               out_res.last = !can_trade;
               step_go      = can_trade;
            end
         end
         default: begin
         end
      endcase
      if (step_go) begin
         bid_ctl.pop = (bid_rem == '0);
         bid_ctl.upd = (bid_rem != '0);
         ask_ctl.pop = (ask_rem == '0);
         ask_ctl.upd = (ask_rem != '0);
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_MATCH) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            if (can_trade) begin
               state_in = ST_NEXT;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_NEXT: begin
            if (out_free && !can_trade) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= out_res;
      end
      if (step_go) begin
         pend_ff <= trade_res;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_trade_valid       = rsp_ff.trade_valid;
   assign rsp_buyer_id          = rsp_ff.buyer_id;
   assign rsp_seller_id         = rsp_ff.seller_id;
   assign rsp_traded_units      = rsp_ff.traded_units;
   assign rsp_trade_price_ticks = rsp_ff.trade_price_ticks;
   assign rsp_overflow          = rsp_ff.overflow;
   assign rsp_last              = rsp_ff.last;

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (bid_ctl.push |-> !bid_full) and (ask_ctl.push |-> !ask_full))
      else $error("Push into a full stack.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (bid_count <= CNT_W'(STACK_DEPTH)) && (ask_count <= CNT_W'(STACK_DEPTH)))
      else $error("Stack count beyond depth.");

   a_match_enters: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_MATCH) |=> (state_ff == ST_FIRST))
      else $error("Match item did not start the sequencer.");

   a_no_result_lost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !out_load)
      else $error("Result register overwritten while stalled.");

endmodule

[sim/lifo_order_matcher_top_tb.sv]
// Testbench for lifo_order_matcher_top: a queue-fed driver, a result monitor and a
// self-checking order book predictor of the bid and ask stacks.
// Depends on lom_pkg and the RTL of lifo_order_matcher_top.
module lifo_order_matcher_top_tb;
   import lom_pkg::*;

   localparam logic SELL = ~BUY;

   typedef struct {
      logic        func;
      logic        side;
      logic [31:0] order_id;
      logic [31:0] price;
      logic [30:0] amount;
      bit          after_idle;
   } order_msg_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = FUNC_ADD;
   logic        req_side = BUY;
   logic [31:0] req_order_id = '0;
   logic [31:0] req_price_ticks = '0;
   logic [30:0] req_amount = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_trade_valid;
   logic [31:0] rsp_buyer_id;
   logic [31:0] rsp_seller_id;
   logic [30:0] rsp_traded_units;
   logic [31:0] rsp_trade_price_ticks;
   logic        rsp_overflow;
   logic        rsp_last;

   order_msg_type  pending_orders[$];
   order_msg_type  next_order;
   lom_result_type expected_fills[$];
   lom_result_type want;
   lom_entry_type  bid_book[STACK_DEPTH];
   lom_entry_type  ask_book[STACK_DEPTH];
   int             bid_depth = 0;
   int             ask_depth = 0;
   int             mismatches = 0;
   int unsigned    orders_taken = 0;
   int unsigned    send_gap = 0;
   int unsigned    recv_gap = 0;
   int unsigned    hold_cycles = 0;
   int unsigned    next_hold_at = 14;
   bit             req_taken = 1'b0;
   bit             hold_next = 1'b0;

   lifo_order_matcher_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_side             (req_side),
      .req_order_id         (req_order_id),
      .req_price_ticks      (req_price_ticks),
      .req_amount           (req_amount),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_trade_valid      (rsp_trade_valid),
      .rsp_buyer_id         (rsp_buyer_id),
      .rsp_seller_id        (rsp_seller_id),
      .rsp_traded_units     (rsp_traded_units),
      .rsp_trade_price_ticks(rsp_trade_price_ticks),
      .rsp_overflow         (rsp_overflow),
      .rsp_last             (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if ((orders_taken / 60) % 5 == 2) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [30:0] small_amount();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 90) return 31'($urandom_range(1, 20));
      return 31'($urandom);
   endfunction

   function automatic void push_order(logic func, logic side, logic [31:0] order_id,
                                      logic [31:0] price, logic [30:0] amount);
      order_msg_type m;
      m.func = func;
      m.side = side;
      m.order_id = order_id;
      m.price = price;
      m.amount = amount;
      m.after_idle = hold_next;
      hold_next = 1'b0;
      pending_orders.push_back(m);
   endfunction

   function automatic void predict_book(logic func, logic side, logic [31:0] order_id,
                                        logic [31:0] price, logic [30:0] amount);
      lom_result_type fill;
      lom_result_type prev_fill;
      lom_entry_type  entry;
      logic [30:0]    qty;
      bit             have_fill;
      fill = '0;
      prev_fill = '0;
      have_fill = 1'b0;
      entry.id = order_id;
      entry.price = price;
      entry.amount = amount;
      if (func != FUNC_MATCH) begin
         if (side == BUY) begin
            if (bid_depth >= STACK_DEPTH) fill.overflow = 1'b1;
            else begin
               bid_book[bid_depth] = entry;
               bid_depth++;
            end
         end else begin
            if (ask_depth >= STACK_DEPTH) fill.overflow = 1'b1;
            else begin
               ask_book[ask_depth] = entry;
               ask_depth++;
            end
         end
         fill.last = 1'b1;
         expected_fills.push_back(fill);
      end else begin
         // Each trade pops at least one top, so the loop always ends.
         while (bid_depth > 0 && ask_depth > 0 &&
                bid_book[bid_depth-1].price >= ask_book[ask_depth-1].price) begin
            if (have_fill) expected_fills.push_back(prev_fill);
            qty = (bid_book[bid_depth-1].amount < ask_book[ask_depth-1].amount) ?
                  bid_book[bid_depth-1].amount : ask_book[ask_depth-1].amount;
            prev_fill = '0;
            prev_fill.trade_valid = 1'b1;
            prev_fill.buyer_id = bid_book[bid_depth-1].id;
            prev_fill.seller_id = ask_book[ask_depth-1].id;
            prev_fill.traded_units = qty;
            prev_fill.trade_price_ticks = ask_book[ask_depth-1].price;
            have_fill = 1'b1;
            bid_book[bid_depth-1].amount = bid_book[bid_depth-1].amount - qty;
            ask_book[ask_depth-1].amount = ask_book[ask_depth-1].amount - qty;
            if (bid_book[bid_depth-1].amount == '0) bid_depth--;
            if (ask_book[ask_depth-1].amount == '0) ask_depth--;
         end
         if (have_fill) begin
            prev_fill.last = 1'b1;
            expected_fills.push_back(prev_fill);
         end else begin
            fill.last = 1'b1;
            expected_fills.push_back(fill);
         end
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] expected_val,
                                       logic [31:0] actual_val);
      if (expected_val !== actual_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, name, expected_val, actual_val);
         mismatches++;
      end
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap = send_gap - 1;
         end else if (pending_orders.size() != 0 &&
                      !(pending_orders[0].after_idle && expected_fills.size() != 0)) begin
            next_order = pending_orders.pop_front();
            req_func <= next_order.func;
            req_side <= next_order.side;
            req_order_id <= next_order.order_id;
            req_price_ticks <= next_order.price;
            req_amount <= next_order.amount;
            req_valid <= 1'b1;
            send_gap = idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else if (orders_taken >= next_hold_at) begin
         rsp_stall <= 1'b1;
         hold_cycles = 200;
         next_hold_at = (next_hold_at == 14) ? 300 : 32'hFFFF_FFFF;
      end else if (recv_gap > 0) begin
         rsp_stall <= 1'b1;
         recv_gap = recv_gap - 1;
      end else begin
         rsp_stall <= 1'b0;
         recv_gap = idle_len();
      end
   end

   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            orders_taken++;
            predict_book(req_func, req_side, req_order_id, req_price_ticks, req_amount);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_fills.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual trade %0b units %0h",
                        $time, rsp_trade_valid, rsp_traded_units);
               mismatches++;
            end else begin
               want = expected_fills.pop_front();
               check_field("trade_valid", 32'(want.trade_valid), 32'(rsp_trade_valid));
               check_field("buyer_id", want.buyer_id, rsp_buyer_id);
               check_field("seller_id", want.seller_id, rsp_seller_id);
               check_field("traded_units", 32'(want.traded_units), 32'(rsp_traded_units));
               check_field("trade_price_ticks", want.trade_price_ticks,
                           rsp_trade_price_ticks);
               check_field("overflow", 32'(want.overflow), 32'(rsp_overflow));
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int unsigned pick;
      int unsigned n_adds;
      int unsigned next_drain;
      logic        s;
      logic [31:0] mid;

      push_order(FUNC_MATCH, 1'($urandom), $urandom, $urandom, 31'($urandom));
      push_order(FUNC_ADD, BUY, 32'hFFFF_FFFF, 32'd100, 31'h7FFF_FFFF);
      push_order(FUNC_ADD, SELL, 32'd0, 32'd200, 31'd5);
      push_order(FUNC_MATCH, 1'($urandom), $urandom, $urandom, 31'($urandom));
      push_order(FUNC_ADD, SELL, 32'd1, 32'd0, 31'd0);
      push_order(FUNC_MATCH, 1'($urandom), $urandom, $urandom, 31'($urandom));
      push_order(FUNC_ADD, BUY, 32'd2, 32'hFFFF_FFFF, 31'd0);
      push_order(FUNC_MATCH, 1'($urandom), $urandom, $urandom, 31'($urandom));
      push_order(FUNC_ADD, BUY, 32'd3, 32'hFFFF_FFFF, 31'd3);
      push_order(FUNC_MATCH, 1'($urandom), $urandom, $urandom, 31'($urandom));
      push_order(FUNC_ADD, SELL, 32'd4, 32'd100, 31'h7FFF_FFFF);
      push_order(FUNC_MATCH, 1'($urandom), $urandom, $urandom, 31'($urandom));
      for (int k = 0; k < STACK_DEPTH + 1; k++)
         push_order(FUNC_ADD, BUY, 32'h100 + 32'(k), 32'd50 + 32'(k), 31'(k + 1));
      push_order(FUNC_ADD, SELL, 32'h200, 32'd0, 31'd1000);
      push_order(FUNC_MATCH, 1'($urandom), $urandom, $urandom, 31'($urandom));

      next_drain = pending_orders.size();
      while (pending_orders.size() < 480) begin
         if (pending_orders.size() >= next_drain) begin
            hold_next = 1'b1;
            next_drain = next_drain + 100;
         end
         pick = $urandom_range(0, 99);
         mid = $urandom;
         if (pick < 55) begin
            n_adds = $urandom_range(1, 6);
            repeat (n_adds)
               push_order(FUNC_ADD, 1'($urandom), $urandom,
                          mid + 32'($urandom_range(0, 16)) - 32'd8, small_amount());
            push_order(FUNC_MATCH, 1'($urandom), $urandom, $urandom, 31'($urandom));
         end else if (pick < 65) begin
            s = 1'($urandom);
            n_adds = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 3);
            repeat (n_adds)
               push_order(FUNC_ADD, s, $urandom, mid + 32'($urandom_range(0, 31)),
                          small_amount());
            push_order(FUNC_ADD, ~s, $urandom, (s == BUY) ? 32'd0 : 32'hFFFF_FFFF,
                       31'($urandom_range(0, 600)));
            push_order(FUNC_MATCH, 1'($urandom), $urandom, $urandom, 31'($urandom));
         end else if (pick < 90) begin
            push_order(1'($urandom), 1'($urandom), $urandom, $urandom, 31'($urandom));
         end else begin
            push_order(FUNC_MATCH, 1'($urandom), $urandom, $urandom, 31'($urandom));
         end
      end

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      while (pending_orders.size() != 0 || req_valid || expected_fills.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

[lifo_order_matcher_top.f]
rtl/core/lom_pkg.sv
rtl/core/lom_cell.sv
rtl/core/lom_stack.sv
rtl/core/lifo_order_matcher_top.sv
sim/lifo_order_matcher_top_tb.sv
